/* hdl/affine_matrix_inverse_macros.svh */
// Assertion macros shared by the affine inverse RTL.
`ifndef AFFINE_MATRIX_INVERSE_MACROS_SVH
`define AFFINE_MATRIX_INVERSE_MACROS_SVH
`ifndef ASSERT_OFF
`define AMI_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
`define AMI_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define AMI_ASSERT_IMPLY(label, clk, rst, cond, expr)
`define AMI_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

/* hdl/ami_pkg.sv */
`default_nettype none
package ami_pkg;
   typedef struct packed {
      logic signed [31:0] in_r0c0;
      logic signed [31:0] in_r0c1;
      logic signed [31:0] in_r0c2;
      logic signed [31:0] in_r0c3;
      logic signed [31:0] in_r1c0;
      logic signed [31:0] in_r1c1;
      logic signed [31:0] in_r1c2;
      logic signed [31:0] in_r1c3;
      logic signed [31:0] in_r2c0;
      logic signed [31:0] in_r2c1;
      logic signed [31:0] in_r2c2;
      logic signed [31:0] in_r2c3;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_r0c0;
      logic signed [31:0] out_r0c1;
      logic signed [31:0] out_r0c2;
      logic signed [31:0] out_r0c3;
      logic signed [31:0] out_r1c0;
      logic signed [31:0] out_r1c1;
      logic signed [31:0] out_r1c2;
      logic signed [31:0] out_r1c3;
      logic signed [31:0] out_r2c0;
      logic signed [31:0] out_r2c1;
      logic signed [31:0] out_r2c2;
      logic signed [31:0] out_r2c3;
   } rsp_type;

   // Determinant width: Q48.48 plus sign and the carries of six terms.
   localparam int DetW = 100;
   localparam int CofW = 66;
   localparam int NumW = 98;  // cofactor shifted up by 32
   localparam int DivSteps = 98;
   localparam int QW = 34;    // quotient bits kept before saturation
   localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
   localparam logic [31:0] SatNeg = 32'h8000_0000;

   // Division bits resolved per pipeline stage.
   localparam int BitsPerStage = 2;
endpackage
`default_nettype wire

/* hdl/ami_div.sv */
`default_nettype none
// Pipelined restoring divider: round(num / den), ties away from zero,
// saturated to 32 bits. One quotient bit per step, two steps per stage.
// Quotient bits above QW only flag overflow.
module ami_div (
   input  wire logic                      clock,
   input  wire logic                      adv,
   input  wire logic                      neg,
   input  wire logic [ami_pkg::NumW-1:0]  num,   // magnitude
   input  wire logic [ami_pkg::DetW-1:0]  den,   // magnitude, nonzero
   output logic      [31:0]               quo
);
   localparam int NS = (ami_pkg::DivSteps + ami_pkg::BitsPerStage - 1) / ami_pkg::BitsPerStage;
   localparam int RW = ami_pkg::DetW + 1;

   logic [RW-1:0]              rem_ff [1:NS];
   logic [ami_pkg::NumW-1:0]   n_ff   [1:NS];
   logic [ami_pkg::DetW-1:0]   d_ff   [1:NS];
   logic [ami_pkg::QW-1:0]     q_ff   [1:NS];
   logic                       ov_ff  [1:NS];
   logic                       ng_ff  [1:NS];
   logic [31:0]                quo_ff;

   for (genvar s = 0; s < NS; s++) begin : g_st
      logic [RW-1:0]            r_src;
      logic [ami_pkg::NumW-1:0] n_src;
      logic [ami_pkg::DetW-1:0] d_src;
      logic [ami_pkg::QW-1:0]   q_src;
      logic                     o_src;
      logic                     g_src;
      logic [RW-1:0]            r_in;
      logic [ami_pkg::NumW-1:0] n_in;
      logic [ami_pkg::QW-1:0]   q_in;
      logic                     o_in;

      // The first stage starts from the raw operands, later ones from the
      // registers of the stage before.
      if (s == 0) begin : g_head
         assign r_src = '0;
         assign n_src = num;
         assign d_src = den;
         assign q_src = '0;
         assign o_src = 1'b0;
         assign g_src = neg;
      end else begin : g_body
         assign r_src = rem_ff[s];
         assign n_src = n_ff[s];
         assign d_src = d_ff[s];
         assign q_src = q_ff[s];
         assign o_src = ov_ff[s];
         assign g_src = ng_ff[s];
      end

      always_comb begin
         logic [RW:0] t;
         r_in = r_src;
         n_in = n_src;
         q_in = q_src;
         o_in = o_src;
         for (int b = 0; b < ami_pkg::BitsPerStage; b++) begin
            t = {r_in, n_in[ami_pkg::NumW-1]};
            n_in = {n_in[ami_pkg::NumW-2:0], 1'b0};
            if (t >= {2'b0, d_src}) begin
               t = t - {2'b0, d_src};
               o_in = o_in | q_in[ami_pkg::QW-1];
               q_in = {q_in[ami_pkg::QW-2:0], 1'b1};
            end else begin
               o_in = o_in | q_in[ami_pkg::QW-1];
               q_in = {q_in[ami_pkg::QW-2:0], 1'b0};
            end
            r_in = t[RW-1:0];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s+1] <= r_in;
            n_ff[s+1]   <= n_in;
            d_ff[s+1]   <= d_src;
            q_ff[s+1]   <= q_in;
            ov_ff[s+1]  <= o_in;
            ng_ff[s+1]  <= g_src;
         end
      end
   end

   // Final stage: extra half step for rounding, then saturation.
   logic [31:0] quo_in;
   always_comb begin
      logic [RW:0]            t;
      logic [ami_pkg::QW:0]   q;
      t = {rem_ff[NS], 1'b0};
      q = {1'b0, q_ff[NS]} + {{ami_pkg::QW{1'b0}}, (t >= {2'b0, d_ff[NS]})};
      if (!ng_ff[NS]) begin
         quo_in = (ov_ff[NS] || q > {3'b0, ami_pkg::SatPos})
                  ? ami_pkg::SatPos : q[31:0];
      end else begin
         quo_in = (ov_ff[NS] || q > {3'b0, ami_pkg::SatNeg})
                  ? ami_pkg::SatNeg : 32'(-q[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) quo_ff <= quo_in;
   end
   assign quo = quo_ff;
endmodule
`default_nettype wire

/* hdl/affine_matrix_inverse.sv */
`default_nettype none
// Affine 3x4 matrix inverse, signed Q16.16. One matrix request is taken per
// cycle while the pipeline advances; its inverse leaves from the output register.
// The path holds 57 register stages: four for the products, the cofactors
// and the exact determinant (its partial products and their sum), 49 stages
// of the pipelined long divider (two quotient bits per stage, nine dividers
// side by side), a rounding stage, then three for the translation products,
// their sum and the final rounding into the output register. Division by
// the determinant dominates the latency. A singular matrix gives an
// all-zero result. The whole pipeline advances together and holds while the
// output register is full and not taken, so the rate only drops when the
// sink stalls.
`include "affine_matrix_inverse_macros.svh"
module affine_matrix_inverse (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire ami_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output ami_pkg::rsp_type     rsp_data
);
   localparam int DivLat = (ami_pkg::DivSteps + ami_pkg::BitsPerStage - 1)
                           / ami_pkg::BitsPerStage + 1;
   // Register stages from input to output register inclusive.
   localparam int Lat = 4 + DivLat + 3;

   logic adv;
   logic [Lat-2:0] vld_ff;
   logic           out_vld_ff;
   ami_pkg::rsp_type out_ff;

   // Pipeline moves when the output slot is free or being emptied.
   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;

   // Stage 1: register inputs, form 2x2 products.
   logic signed [31:0] a_ff [9];
   logic signed [31:0] t1_ff [3];
   logic signed [63:0] p_ff [18];
   logic signed [31:0] a_in [9];
   always_comb begin
      a_in[0] = req_data.in_r0c0; a_in[1] = req_data.in_r0c1;
      a_in[2] = req_data.in_r0c2; a_in[3] = req_data.in_r1c0;
      a_in[4] = req_data.in_r1c1; a_in[5] = req_data.in_r1c2;
      a_in[6] = req_data.in_r2c0; a_in[7] = req_data.in_r2c1;
      a_in[8] = req_data.in_r2c2;
   end
   // Cofactor k = a[m0]*a[m1] - a[m2]*a[m3], sign applied later.
   localparam int M0 [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
   localparam int M1 [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
   localparam int M2 [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
   localparam int M3 [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
   localparam bit Ng [9] = '{0, 1, 0, 1, 0, 1, 0, 1, 0};

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) begin
            a_ff[k]      <= a_in[k];
            p_ff[2*k]    <= a_in[M0[k]] * a_in[M1[k]];
            p_ff[2*k+1]  <= a_in[M2[k]] * a_in[M3[k]];
         end
         t1_ff[0] <= req_data.in_r0c3;
         t1_ff[1] <= req_data.in_r1c3;
         t1_ff[2] <= req_data.in_r2c3;
      end
   end

   // Stage 2: cofactors.
   logic signed [ami_pkg::CofW-1:0] c_ff [9];
   logic signed [31:0] a2_ff [3];
   logic signed [31:0] t2_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) begin
            if (Ng[k])
               c_ff[k] <= 66'(p_ff[2*k+1]) - 66'(p_ff[2*k]);
            else
               c_ff[k] <= 66'(p_ff[2*k]) - 66'(p_ff[2*k+1]);
         end
         a2_ff[0] <= a_ff[0]; a2_ff[1] <= a_ff[1]; a2_ff[2] <= a_ff[2];
         t2_ff <= t1_ff;
      end
   end

   // Stage 3: partial products of the determinant, which is row 0 dotted
   // with the first cofactor column. Each 66-bit cofactor is split into a
   // signed high half and an unsigned low half of 33 bits each.
   logic signed [65:0] dlo_ff [3];
   logic signed [64:0] dhi_ff [3];
   logic signed [ami_pkg::CofW-1:0] c3_ff [9];
   logic signed [31:0] t3_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            dlo_ff[j] <= 66'(a2_ff[j]) * 66'($signed({1'b0, c_ff[3*j][32:0]}));
            dhi_ff[j] <= 65'(a2_ff[j]) * 65'($signed(c_ff[3*j][65:33]));
         end
         c3_ff <= c_ff;
         t3_ff <= t2_ff;
      end
   end

   // Stage 4: determinant from the partial products.
   logic signed [ami_pkg::DetW-1:0] det_ff;
   logic signed [ami_pkg::CofW-1:0] c4_ff [9];
   logic signed [31:0] t4_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff <= ((100'(dhi_ff[0]) + 100'(dhi_ff[1]) + 100'(dhi_ff[2])) <<< 33)
                 + 100'(dlo_ff[0]) + 100'(dlo_ff[1]) + 100'(dlo_ff[2]);
         c4_ff <= c3_ff;
         t4_ff <= t3_ff;
      end
   end

   // Division pipeline: element (r,c) = cofactor(c,r) / det.
   // Cofactor index k = 3*i + j holds cofactor row j of column i.
   logic [ami_pkg::DetW-1:0] dmag;
   logic dneg;
   assign dneg = det_ff[ami_pkg::DetW-1];
   assign dmag = dneg ? 100'(-det_ff) : det_ff;
   logic [31:0] lin [9];
   for (genvar k = 0; k < 9; k++) begin : g_div
      logic cneg;
      logic [ami_pkg::CofW-1:0] cmag;
      assign cneg = c4_ff[k][ami_pkg::CofW-1];
      assign cmag = cneg ? 66'(-c4_ff[k]) : c4_ff[k];
      ami_div u_div (
         .clock (clock),
         .adv   (adv),
         .neg   (cneg ^ dneg),
         .num   ({cmag[ami_pkg::NumW-33:0], 32'b0}),
         .den   (dmag),
         .quo   (lin[k])
      );
   end

   // Delay translation and singular flag alongside the divider.
   logic signed [31:0] td_ff [DivLat][3];
   logic               zd_ff [DivLat];
   always_ff @(posedge clock) begin
      if (adv) begin
         td_ff[0] <= t4_ff;
         zd_ff[0] <= (det_ff == '0);
         for (int s = 1; s < DivLat; s++) begin
            td_ff[s] <= td_ff[s-1];
            zd_ff[s] <= zd_ff[s-1];
         end
      end
   end

   // Linear entry of output row r, column c comes from divider 3*r... via
   // cofactor index: a_ff order (r,c) maps to cofactor k = 3*r + c above,
   // whose values are already the inverse entries (adjugate ordering).
   // Translation stage A: products t_j * lin(r,j).
   logic signed [63:0] tp_ff [9];
   logic signed [31:0] l_ff [9];
   logic               z_a_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) begin
            tp_ff[k] <= td_ff[DivLat-1][k % 3] * $signed(lin[k]);
            l_ff[k]  <= lin[k];
         end
         z_a_ff <= zd_ff[DivLat-1];
      end
   end

   // Stage B: sums negated.
   logic signed [65:0] ts_ff [3];
   logic signed [31:0] l2_ff [9];
   logic               z_b_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++)
            ts_ff[r] <= -(66'(tp_ff[3*r]) + 66'(tp_ff[3*r+1]) + 66'(tp_ff[3*r+2]));
         l2_ff  <= l_ff;
         z_b_ff <= z_a_ff;
      end
   end

   // Stage C: round, saturate, pack into output register.
   logic [31:0] tr [3];
   always_comb begin
      logic [65:0] m;
      logic [66:0] mr;
      for (int r = 0; r < 3; r++) begin
         m  = ts_ff[r][65] ? 66'(-ts_ff[r]) : 66'(ts_ff[r]);
         mr = (67'(m) + 67'h8000) >> 16;
         if (!ts_ff[r][65])
            tr[r] = (mr > 67'(ami_pkg::SatPos)) ? ami_pkg::SatPos : mr[31:0];
         else
            tr[r] = (mr > 67'(ami_pkg::SatNeg)) ? ami_pkg::SatNeg : 32'(-mr[31:0]);
      end
   end

   // The valid bits shadow every register stage before the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[Lat-3:0], req_valid};
         out_vld_ff <= vld_ff[Lat-2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (z_b_ff) begin
            out_ff <= '0;
         end else begin
            out_ff <= {l2_ff[0], l2_ff[1], l2_ff[2], tr[0],
                       l2_ff[3], l2_ff[4], l2_ff[5], tr[1],
                       l2_ff[6], l2_ff[7], l2_ff[8], tr[2]};
         end
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   `AMI_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `AMI_ASSERT_IMPLY(a_ready, clock, reset, !rsp_valid, req_ready)
   `AMI_ASSERT_NEXT(a_stall, clock, reset, !adv, $stable(vld_ff))
endmodule
`default_nettype wire

/* dv/testbench.sv */
`default_nettype none
// Self-checking bench for the affine 3x4 inverse. Every request accepted on the
// input channel is inverted here by an independent model, and the result is
// queued. Each response taken on the output channel must match the oldest
// queued result, field by field.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Wide enough for every exact intermediate: the determinant needs about
   // 100 bits and the shifted cofactor about 98.
   typedef logic signed [199:0] wide_type;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned DrainCycles = 120;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   ami_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   ami_pkg::rsp_type rsp_data;

   ami_pkg::rsp_type inverse_queue[$];
   int unsigned error_count;
   int unsigned cycle_count;
   bit          calm;        // when set, neither side idles unless hold_left is set
   int unsigned hold_left;   // cycles for which the sink still refuses responses

   affine_matrix_inverse u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Model of the inverse.
   // ------------------------------------------------------------------

   // Clamps a signed magnitude to the Q16.16 range and returns the pattern.
   function automatic logic [31:0] clamp_q16(bit neg, wide_type mag);
      if (!neg) begin
         if (mag > wide_type'(64'h7FFF_FFFF)) return ami_pkg::SatPos;
         return mag[31:0];
      end
      if (mag > wide_type'(64'h8000_0000)) return ami_pkg::SatNeg;
      return -mag[31:0];
   endfunction

   // Quotient rounded to nearest, ties away from zero; den is never zero.
   function automatic logic [31:0] rounded_quotient(wide_type num, wide_type den);
      bit       neg;
      wide_type un;
      wide_type ud;
      wide_type q;
      wide_type r;
      neg = (num < 0) != (den < 0);
      un  = (num < 0) ? -num : num;
      ud  = (den < 0) ? -den : den;
      q   = un / ud;
      r   = un % ud;
      if ((r <<< 1) >= ud) q = q + 1;
      return clamp_q16(neg, q);
   endfunction

   // Translation entry: minus the dot product of the source translation with
   // the already rounded row of the inverse, rounded back to Q16.16.
   function automatic logic [31:0] inverse_shift(wide_type t0, wide_type t1, wide_type t2,
                                                 logic [31:0] r0, logic [31:0] r1,
                                                 logic [31:0] r2);
      wide_type acc;
      wide_type mag;
      bit       neg;
      acc = t0 * wide_type'($signed(r0)) + t1 * wide_type'($signed(r1))
            + t2 * wide_type'($signed(r2));
      acc = -acc;
      neg = acc < 0;
      mag = ((neg ? -acc : acc) + wide_type'(32'h8000)) >>> 16;
      return clamp_q16(neg, mag);
   endfunction

   function automatic ami_pkg::rsp_type invert_affine(ami_pkg::req_type m);
      wide_type     a[12];
      wide_type     det;
      wide_type     cof[9];
      logic [31:0]  o[12];
      logic [383:0] bits;
      bits = m;
      for (int k = 0; k < 12; k++) a[k] = wide_type'($signed(bits[383 - 32 * k -: 32]));
      // Index k = 4 * row + column; column 3 is the translation.
      det = a[0] * a[5] * a[10] + a[4] * a[9] * a[2] + a[8] * a[1] * a[6]
            - a[8] * a[5] * a[2] - a[4] * a[1] * a[10] - a[0] * a[9] * a[6];
      if (det == 0) return '0;
      // Adjugate entries with the cofactor signs already applied.
      cof[0] =   a[5] * a[10] - a[9] * a[6];
      cof[1] = -(a[1] * a[10] - a[9] * a[2]);
      cof[2] =   a[1] * a[6]  - a[5] * a[2];
      cof[3] = -(a[4] * a[10] - a[8] * a[6]);
      cof[4] =   a[0] * a[10] - a[8] * a[2];
      cof[5] = -(a[0] * a[6]  - a[4] * a[2]);
      cof[6] =   a[4] * a[9]  - a[8] * a[5];
      cof[7] = -(a[0] * a[9]  - a[8] * a[1]);
      cof[8] =   a[0] * a[5]  - a[4] * a[1];
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            o[4 * r + c] = rounded_quotient(cof[3 * r + c] <<< 32, det);
         end
         o[4 * r + 3] = inverse_shift(a[3], a[7], a[11],
                                      o[4 * r], o[4 * r + 1], o[4 * r + 2]);
      end
      for (int k = 0; k < 12; k++) bits[383 - 32 * k -: 32] = o[k];
      return ami_pkg::rsp_type'(bits);
   endfunction

   // ------------------------------------------------------------------
   // Driving requests.
   // ------------------------------------------------------------------

   // Offers one matrix and holds it until taken, then queues its inverse.
   // Valid stays high into the next request unless the sender idles; each
   // cycle after a request is idle with a chance of about one in four.
   task automatic send_matrix(ami_pkg::req_type m);
      req_valid <= 1'b1;
      req_data  <= m;
      do @(posedge clock); while (!req_ready);
      inverse_queue.push_back(invert_affine(m));
      while (!calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Builds a matrix from twelve entries given row by row.
   function automatic ami_pkg::req_type pack_matrix(logic [31:0] e[12]);
      logic [383:0] bits;
      for (int k = 0; k < 12; k++) bits[383 - 32 * k -: 32] = e[k];
      return ami_pkg::req_type'(bits);
   endfunction

   // One entry of a given flavour: 0 full range, 1 near 1.0, 2 small,
   // 3 a power of two with random sign, 4 zero, an extreme or all ones.
   function automatic logic [31:0] random_entry(int flavour);
      case (flavour)
         0: return $urandom;
         1: return 32'h0001_0000 + $urandom_range(0, 32'h4000) - 32'h2000;
         2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         3: return ($urandom_range(0, 1) ? -32'sd1 : 32'sd1) <<< $urandom_range(0, 30);
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h0000_0000;
               1: return ami_pkg::SatPos;
               2: return ami_pkg::SatNeg;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   // A random matrix of one of several shapes.
   function automatic ami_pkg::req_type random_matrix();
      logic [31:0] e[12];
      int          shape;
      shape = $urandom_range(0, 9);
      for (int k = 0; k < 12; k++) begin
         case (shape)
            0, 1:    e[k] = random_entry(0);
            2, 3, 4: e[k] = ((k % 5) == 0) ? random_entry(1) : random_entry(2);
            5:       e[k] = random_entry(2);
            6:       e[k] = random_entry(3);
            7:       e[k] = random_entry($urandom_range(0, 4));
            default: e[k] = ((k % 5) == 0) ? random_entry(3) : random_entry(2);
         endcase
      end
      // Now and then make the linear part singular by copying a row.
      if (shape == 9 || $urandom_range(0, 19) == 0) begin
         for (int c = 0; c < 3; c++) e[8 + c] = e[c];
      end
      return pack_matrix(e);
   endfunction

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   task automatic test_special_matrices();
      logic [31:0] e[12];
      localparam logic [31:0] One = 32'h0001_0000;
      localparam logic [31:0] Pmax = ami_pkg::SatPos;
      localparam logic [31:0] Nmax = ami_pkg::SatNeg;
      // Identity, then identity with a translation.
      e = '{One, 0, 0, 0, 0, One, 0, 0, 0, 0, One, 0};
      send_matrix(pack_matrix(e));
      e = '{One, 0, 0, 32'h0003_8000, 0, One, 0, 32'hFFFE_0000, 0, 0, One, Pmax};
      send_matrix(pack_matrix(e));
      // Uniform scale by two and by a half: the inverse is exact.
      e = '{32'h0002_0000, 0, 0, One, 0, 32'h0002_0000, 0, One, 0, 0, 32'h0002_0000, One};
      send_matrix(pack_matrix(e));
      e = '{32'h0000_8000, 0, 0, Nmax, 0, 32'h0000_8000, 0, 0, 0, 0, 32'h0000_8000, 0};
      send_matrix(pack_matrix(e));
      // Singular: all zero, two equal rows, a zero column.
      e = '{default: 0};
      send_matrix(pack_matrix(e));
      e = '{One, 2 * One, 3 * One, 5, One, 2 * One, 3 * One, 6, 0, One, 0, 7};
      send_matrix(pack_matrix(e));
      e = '{0, One, One, One, 0, 2 * One, One, One, 0, One, 3 * One, One};
      send_matrix(pack_matrix(e));
      // Extremes of every field; the all-equal cases are singular.
      e = '{default: Pmax};
      send_matrix(pack_matrix(e));
      e = '{default: Nmax};
      send_matrix(pack_matrix(e));
      e = '{Pmax, 0, 0, Nmax, 0, Nmax, 0, Pmax, 0, 0, Pmax, Nmax};
      send_matrix(pack_matrix(e));
      e = '{Nmax, 0, 0, Pmax, 0, Nmax, 0, Pmax, 0, 0, Nmax, 32'hFFFF_FFFF};
      send_matrix(pack_matrix(e));
      // Tiny diagonal: the inverse saturates both ways.
      e = '{32'h1, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 32'h1, 0};
      send_matrix(pack_matrix(e));
      e = '{32'h1, 0, 0, One, 0, 32'h1, 0, Nmax, 0, 0, 32'h1, Pmax};
      send_matrix(pack_matrix(e));
      // Rotation-like permutation with a sign flip and a shear.
      e = '{0, One, 0, One, 32'hFFFF_0000, 0, 0, 2 * One, 0, 0, One, 3 * One};
      send_matrix(pack_matrix(e));
      e = '{One, 32'h0000_4000, 0, 0, 0, One, 32'h0000_4000, 0, 0, 0, One, One};
      send_matrix(pack_matrix(e));
      // Scale by three: quotients that land on rounding ties and near-ties.
      e = '{3 * One, 0, 0, 1, 0, 3 * One, 0, 32'hFFFF_FFFF, 0, 0, 3 * One, 2};
      send_matrix(pack_matrix(e));
      e = '{32'h0000_0002, 0, 0, 32'h0000_0003, 0, One, 0, 0, 0, 0, One, 0};
      send_matrix(pack_matrix(e));
      // Huge diagonal: the inverse is very small.
      e = '{Pmax, 1, 0, One, 1, Pmax, 0, One, 0, 0, Pmax, One};
      send_matrix(pack_matrix(e));
   endtask

   task automatic test_random_matrices(int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         // The middle stretch runs with both sides always willing.
         calm = (n >= count / 3) && (n < count / 3 + 150);
         send_matrix(random_matrix());
      end
      calm = 1'b0;
   endtask

   // The sink refuses responses for a long while and the source keeps
   // offering, so the pipeline fills and request ready must drop.
   task automatic test_output_stall();
      calm      = 1'b1;
      hold_left = 400;
      for (int n = 0; n < 120; n++) send_matrix(random_matrix());
      calm = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Response sink and checking.
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= $urandom_range(0, 99) >= 26;
      end
   end

   always @(posedge clock) begin
      ami_pkg::rsp_type want;
      logic [383:0]     wb;
      logic [383:0]     gb;
      if (!reset && rsp_valid && rsp_ready) begin
         if (inverse_queue.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = inverse_queue.pop_front();
            wb   = want;
            gb   = rsp_data;
            for (int k = 0; k < 12; k++) begin
               if (gb[383 - 32 * k -: 32] !== wb[383 - 32 * k -: 32]) begin
                  $error("out_r%0dc%0d expected %h actual %h", k / 4, k % 4,
                         wb[383 - 32 * k -: 32], gb[383 - 32 * k -: 32]);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("affine_matrix_inverse regression: fail");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      error_count = 0;
      cycle_count = 0;
      calm        = 1'b0;
      hold_left   = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_matrices();
      test_random_matrices(400);
      test_output_stall();
      test_random_matrices(280);

      req_valid <= 1'b0;
      while (inverse_queue.size() != 0) @(posedge clock);
      // Let any stray response from the pipeline show itself.
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0) begin
         $display("affine_matrix_inverse regression: pass");
      end else begin
         $display("affine_matrix_inverse regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
